// ===== hw/rtl/ccp_pkg.sv =====
// Shared types and constants for the three-point circle center pipeline.
package ccp_pkg;

  localparam int NORMAL_W  = 42;
  localparam int CENTER_W  = 32;
  localparam int MUL_CHUNK = 24;
  localparam int MUL_LAT   = 5;
  localparam int QUO_BITS  = 34;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_COINCIDENT = 2'd1;
  localparam status_t ST_COLLINEAR  = 2'd2;
  localparam status_t ST_SATURATED  = 2'd3;

endpackage

// ===== hw/rtl/circle_center_from_three_points.sv =====
// Top level: circle center and plane normal from three 3D points.
//
// Input channel: in_valid / in_stall carry one beat of three points (start,
// via, end), each coordinate COORD_BITS signed. A beat is taken at a rising
// edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result beat per input beat:
// status, the circle center (32-bit signed, truncated toward zero and
// saturated) and the normal (via-start) x (end-start), low 42 bits.
// Two 5-stage chunked multipliers in series and a 34-stage restoring divider,
// one quotient bit per stage, make up the pipeline.
// Throughput is one beat per cycle unless stalled; all stages advance together.
// Status: 0 ok, 1 two points coincide, 2 collinear (center reads 0 for both),
// 3 a center component saturated.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
module circle_center_from_three_points
  import ccp_pkg::*;
#(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] via_x,
  input  logic signed [COORD_BITS-1:0] via_y,
  input  logic signed [COORD_BITS-1:0] via_z,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic signed [CENTER_W-1:0]   center_x,
  output logic signed [CENTER_W-1:0]   center_y,
  output logic signed [CENTER_W-1:0]   center_z,
  output logic signed [NORMAL_W-1:0]   normal_x,
  output logic signed [NORMAL_W-1:0]   normal_y,
  output logic signed [NORMAL_W-1:0]   normal_z
);

  localparam int C    = COORD_BITS;
  localparam int AW   = C + 1;
  localparam int PW   = 2 * AW;
  localparam int NRW  = PW + 1;
  localparam int DOTW = PW + 2;
  localparam int DFW  = DOTW + 1;
  localparam int KW   = DOTW + DFW;
  localparam int SQW  = 2 * DOTW;
  localparam int DENW = SQW + 2;
  localparam int KAW  = KW + AW;
  localparam int NUMW = KAW + 1;
  localparam int OVW  = (NUMW > DENW + QUO_BITS) ? NUMW : DENW + QUO_BITS;
  localparam int NXW  = (NRW > NORMAL_W) ? NRW : NORMAL_W;
  localparam int SW   = QUO_BITS + 2;
  localparam int ML   = MUL_LAT;
  localparam int LO   = 7 + 2 * ML + QUO_BITS;

  localparam logic signed [SW-1:0] HI_LIM = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] LO_LIM = ~HI_LIM;

  logic          adv;
  logic [LO:1]   vld;

  assign adv       = !vld[LO] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[LO];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LO-1:1], in_valid};
    end
  end

  // stage 1: differences
  logic signed [AW-1:0] a_c [3];
  logic signed [AW-1:0] b_c [3];
  logic signed [C-1:0]  p_c [3];
  logic signed [AW-1:0] a1 [3];
  logic signed [AW-1:0] b1 [3];
  logic signed [C-1:0]  p1 [3];
  logic                 coin1;

  assign p_c[0] = start_x;
  assign p_c[1] = start_y;
  assign p_c[2] = start_z;
  assign a_c[0] = AW'(via_x) - AW'(start_x);
  assign a_c[1] = AW'(via_y) - AW'(start_y);
  assign a_c[2] = AW'(via_z) - AW'(start_z);
  assign b_c[0] = AW'(end_x) - AW'(start_x);
  assign b_c[1] = AW'(end_y) - AW'(start_y);
  assign b_c[2] = AW'(end_z) - AW'(start_z);

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= a_c;
      b1 <= b_c;
      p1 <= p_c;
      coin1 <= (a_c[0] == '0 && a_c[1] == '0 && a_c[2] == '0)
            || (b_c[0] == '0 && b_c[1] == '0 && b_c[2] == '0)
            || (a_c[0] == b_c[0] && a_c[1] == b_c[1] && a_c[2] == b_c[2]);
    end
  end

  // stage 2: products
  logic signed [PW-1:0] xp2 [6];
  logic signed [PW-1:0] sa2 [3];
  logic signed [PW-1:0] sb2 [3];
  logic signed [PW-1:0] sab2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      xp2[0] <= a1[1] * b1[2];
      xp2[1] <= a1[2] * b1[1];
      xp2[2] <= a1[2] * b1[0];
      xp2[3] <= a1[0] * b1[2];
      xp2[4] <= a1[0] * b1[1];
      xp2[5] <= a1[1] * b1[0];
      for (int i = 0; i < 3; i++) begin
        sa2[i]  <= a1[i] * a1[i];
        sb2[i]  <= b1[i] * b1[i];
        sab2[i] <= a1[i] * b1[i];
      end
    end
  end

  // stage 3: normal and dot products
  logic signed [NRW-1:0]  n3 [3];
  logic signed [DOTW-1:0] aa3;
  logic signed [DOTW-1:0] bb3;
  logic signed [DOTW-1:0] ab3;

  always_ff @(posedge clk) begin
    if (adv) begin
      n3[0] <= NRW'(xp2[0]) - NRW'(xp2[1]);
      n3[1] <= NRW'(xp2[2]) - NRW'(xp2[3]);
      n3[2] <= NRW'(xp2[4]) - NRW'(xp2[5]);
      aa3 <= DOTW'(sa2[0]) + DOTW'(sa2[1]) + DOTW'(sa2[2]);
      bb3 <= DOTW'(sb2[0]) + DOTW'(sb2[1]) + DOTW'(sb2[2]);
      ab3 <= DOTW'(sab2[0]) + DOTW'(sab2[1]) + DOTW'(sab2[2]);
    end
  end

  // stage 4: operands of the wide products
  logic signed [DOTW-1:0] aa4;
  logic signed [DOTW-1:0] bb4;
  logic signed [DOTW-1:0] ab4;
  logic signed [DFW-1:0]  dab4;
  logic signed [DFW-1:0]  dba4;

  always_ff @(posedge clk) begin
    if (adv) begin
      aa4  <= aa3;
      bb4  <= bb3;
      ab4  <= ab3;
      dab4 <= DFW'(aa3) - DFW'(ab3);
      dba4 <= DFW'(bb3) - DFW'(ab3);
    end
  end

  logic signed [KW-1:0]  ka9;
  logic signed [KW-1:0]  kb9;
  logic signed [SQW-1:0] aabb9;
  logic signed [SQW-1:0] abab9;

  ccp_mul #(.WA(DOTW), .WB(DFW)) u_mul_ka (
    .clk(clk), .en(adv), .a(bb4), .b(dab4), .p(ka9)
  );
  ccp_mul #(.WA(DOTW), .WB(DFW)) u_mul_kb (
    .clk(clk), .en(adv), .a(aa4), .b(dba4), .p(kb9)
  );
  ccp_mul #(.WA(DOTW), .WB(DOTW)) u_mul_aabb (
    .clk(clk), .en(adv), .a(aa4), .b(bb4), .p(aabb9)
  );
  ccp_mul #(.WA(DOTW), .WB(DOTW)) u_mul_abab (
    .clk(clk), .en(adv), .a(ab4), .b(ab4), .p(abab9)
  );

  // denominator
  logic signed [DENW-1:0] den10;
  logic                   denz10;
  logic [DENW-1:0]        den15;

  always_ff @(posedge clk) begin
    if (adv) begin
      den10  <= (DENW'(aabb9) - DENW'(abab9)) <<< 1;
      denz10 <= (aabb9 == abab9);
    end
  end

  ccp_delay #(.W(DENW), .N(ML)) u_dly_den (
    .clk(clk), .en(adv), .d(den10), .q(den15)
  );

  // a and b aligned to the second product rank
  logic [6*AW-1:0] ab_d;

  ccp_delay #(.W(6*AW), .N(3 + ML)) u_dly_ab (
    .clk(clk), .en(adv),
    .d({a1[0], a1[1], a1[2], b1[0], b1[1], b1[2]}),
    .q(ab_d)
  );

  logic signed [KAW-1:0]  kax [3];
  logic signed [KAW-1:0]  kbx [3];
  logic signed [NUMW-1:0] num15 [3];

  for (genvar i = 0; i < 3; i++) begin : g_num
    ccp_mul #(.WA(KW), .WB(AW)) u_mul_a (
      .clk(clk), .en(adv), .a(ka9),
      .b($signed(ab_d[(5-i)*AW +: AW])), .p(kax[i])
    );
    ccp_mul #(.WA(KW), .WB(AW)) u_mul_b (
      .clk(clk), .en(adv), .a(kb9),
      .b($signed(ab_d[(2-i)*AW +: AW])), .p(kbx[i])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        num15[i] <= NUMW'(kax[i]) + NUMW'(kbx[i]);
      end
    end
  end

  // magnitude, overflow check, divide
  logic [NUMW-1:0]     mag_c [3];
  logic [NUMW-1:0]     mag16 [3];
  logic [2:0]          neg16;
  logic [2:0]          ovf16;
  logic [DENW-1:0]     den16;
  logic [QUO_BITS-1:0] quo [3];
  logic [5:0]          no_d;

  for (genvar i = 0; i < 3; i++) begin : g_div
    assign mag_c[i] = num15[i][NUMW-1] ? (~num15[i] + 1'b1) : num15[i];
    always_ff @(posedge clk) begin
      if (adv) begin
        mag16[i] <= mag_c[i];
        neg16[i] <= num15[i][NUMW-1];
        ovf16[i] <= OVW'(mag_c[i]) >= (OVW'(den15) << QUO_BITS);
      end
    end
    ccp_div #(.MW(NUMW), .DW(DENW), .QB(QUO_BITS)) u_div (
      .clk(clk), .en(adv), .num(mag16[i]), .den(den16), .quo(quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den16 <= den15;
    end
  end

  ccp_delay #(.W(6), .N(QUO_BITS)) u_dly_no (
    .clk(clk), .en(adv), .d({neg16, ovf16}), .q(no_d)
  );

  // side data aligned to the quotient
  logic [3*C:0]     pc_d;
  logic [3*NRW-1:0] n_d;
  logic             denz_d;

  ccp_delay #(.W(3*C+1), .N(5 + 2*ML + QUO_BITS)) u_dly_p (
    .clk(clk), .en(adv), .d({coin1, p1[0], p1[1], p1[2]}), .q(pc_d)
  );
  ccp_delay #(.W(3*NRW), .N(3 + 2*ML + QUO_BITS)) u_dly_n (
    .clk(clk), .en(adv), .d({n3[0], n3[1], n3[2]}), .q(n_d)
  );
  ccp_delay #(.W(1), .N(1 + ML + QUO_BITS)) u_dly_dz (
    .clk(clk), .en(adv), .d(denz10), .q(denz_d)
  );

  // final stage: sign, offset, saturate
  logic signed [CENTER_W-1:0] cen_c [3];
  logic [2:0]                 sat_c;
  logic signed [NXW-1:0]      nx_c [3];
  logic                       coin_d;

  assign coin_d = pc_d[3*C];

  for (genvar i = 0; i < 3; i++) begin : g_fin
    logic signed [SW-1:0] sq;
    logic signed [SW-1:0] s;
    logic                 hi;
    logic                 lo;
    logic                 ng;
    logic                 ov;
    assign ng = no_d[3 + i];
    assign ov = no_d[i];
    assign sq = ng ? -$signed(SW'(quo[i])) : $signed(SW'(quo[i]));
    assign s  = sq + SW'($signed(pc_d[(2-i)*C +: C]));
    assign hi = (ov && !ng) || (!ov && s > HI_LIM);
    assign lo = (ov && ng) || (!ov && s < LO_LIM);
    assign sat_c[i] = hi || lo;
    assign cen_c[i] = hi ? CENTER_W'(HI_LIM) : lo ? CENTER_W'(LO_LIM) : s[CENTER_W-1:0];
    assign nx_c[i]  = NXW'($signed(n_d[(2-i)*NRW +: NRW]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (coin_d) begin
        status <= ST_COINCIDENT;
      end else if (denz_d) begin
        status <= ST_COLLINEAR;
      end else if (sat_c != '0) begin
        status <= ST_SATURATED;
      end else begin
        status <= ST_OK;
      end
      if (coin_d || denz_d) begin
        center_x <= '0;
        center_y <= '0;
        center_z <= '0;
      end else begin
        center_x <= cen_c[0];
        center_y <= cen_c[1];
        center_z <= cen_c[2];
      end
      normal_x <= nx_c[0][NORMAL_W-1:0];
      normal_y <= nx_c[1][NORMAL_W-1:0];
      normal_z <= nx_c[2][NORMAL_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/ccp_delay.sv =====
// Enabled delay line that keeps side data aligned with the pipeline.
module ccp_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int k = 1; k < N; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign q = line[N-1];

endmodule

// ===== hw/rtl/ccp_mul.sv =====
// Pipelined signed multiplier built from chunk partial products.
module ccp_mul
  import ccp_pkg::*;
#(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);

  localparam int CW  = MUL_CHUNK;
  localparam int NA  = (WA + CW - 1) / CW;
  localparam int NB  = (WB + CW - 1) / CW;
  localparam int RSW = NB * CW + CW;
  localparam int TW  = (NA + NB) * CW;

  logic [WA-1:0]      ma;
  logic [WB-1:0]      mb;
  logic [NA*CW-1:0]   pa;
  logic [NB*CW-1:0]   pb;
  logic [2*CW-1:0]    pp [NA][NB];
  logic [RSW-1:0]     row_c [NA];
  logic [RSW-1:0]     row [NA];
  logic [TW-1:0]      tot_c;
  logic [TW-1:0]      tot;
  logic [3:0]         sg;

  assign pa = (NA*CW)'(ma);
  assign pb = (NB*CW)'(mb);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_c[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_c[i] = row_c[i] + (RSW'(pp[i][j]) << (j * CW));
      end
    end
    tot_c = '0;
    for (int i = 0; i < NA; i++) begin
      tot_c = tot_c + (TW'(row[i]) << (i * CW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma <= a[WA-1] ? (~a + 1'b1) : a;
      mb <= b[WB-1] ? (~b + 1'b1) : b;
      sg[0] <= a[WA-1] ^ b[WB-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= pa[i*CW +: CW] * pb[j*CW +: CW];
        end
      end
      row <= row_c;
      tot <= tot_c;
      sg[3:1] <= sg[2:0];
      p <= (WA+WB)'(sg[3] ? (~tot + 1'b1) : tot);
    end
  end

endmodule

// ===== hw/rtl/ccp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ccp_div #(
  parameter int MW = 64,
  parameter int DW = 32,
  parameter int QB = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  localparam int RW = (MW > DW + QB) ? MW : DW + QB;

  logic [RW-1:0] rem [QB];
  logic [DW-1:0] dn  [QB];
  logic [QB-1:0] qq  [QB+1];

  assign rem[0] = RW'(num);
  assign dn[0]  = den;
  assign qq[0]  = '0;
  assign quo    = qq[QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [RW-1:0] trial;
    logic          fits;
    assign trial = RW'(dn[k]) << SH;
    assign fits  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        qq[k+1] <= fits ? (qq[k] | (QB'(1) << SH)) : qq[k];
      end
    end

    if (k < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= fits ? (rem[k] - trial) : rem[k];
          dn[k+1]  <= dn[k];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ccp_checker.sv =====
// Port-level checker for the circle center block, with its bind.
module ccp_checker
  import ccp_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 status,
  input logic signed [CENTER_W-1:0] center_x,
  input logic signed [CENTER_W-1:0] center_y,
  input logic signed [CENTER_W-1:0] center_z,
  input logic signed [NORMAL_W-1:0] normal_x,
  input logic signed [NORMAL_W-1:0] normal_y,
  input logic signed [NORMAL_W-1:0] normal_z
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(center_x))
    else $error("held result beat changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input beat dropped");

  a_degen_center: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_COINCIDENT || status == ST_COLLINEAR)
      |-> center_x == '0 && center_y == '0 && center_z == '0)
    else $error("degenerate beat with nonzero center");

  a_degen_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_COINCIDENT || status == ST_COLLINEAR)
      |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate beat with nonzero normal");

endmodule

bind circle_center_from_three_points ccp_checker u_ccp_checker (.*);

// ===== sim/tb_circle_center_from_three_points.sv =====
// Testbench for the three-point circle center block: directed table, then random point triples.
module tb_circle_center_from_three_points;
  import ccp_pkg::*;

  localparam int CB       = 20;
  localparam int N_RANDOM = 1550;
  localparam int N_DIR    = 12;
  localparam int IDLE_MAX = 2000;
  localparam int DRAIN    = 60;
  localparam int CMAX     = 524287;
  localparam int CMIN     = -524288;

  typedef struct {
    logic signed [CB-1:0] v[9];
  } triple_t;

  typedef struct {
    status_t                    st;
    logic signed [CENTER_W-1:0] cx, cy, cz;
    logic signed [NORMAL_W-1:0] nx, ny, nz;
  } center_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [CB-1:0] via_x = '0, via_y = '0, via_z = '0;
  logic signed [CB-1:0] end_x = '0, end_y = '0, end_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic signed [CENTER_W-1:0] center_x, center_y, center_z;
  logic signed [NORMAL_W-1:0] normal_x, normal_y, normal_z;

  center_t centers_due[$];
  int      errors = 0;
  int      n_sent = 0;
  int      n_got  = 0;
  int      st_seen[4] = '{0, 0, 0, 0};
  int      idle_cycles = 0;
  bit      hold_req = 1'b0;

  circle_center_from_three_points #(.COORD_BITS(CB)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .via_x(via_x), .via_y(via_y), .via_z(via_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic center_t predict_center(triple_t t);
    logic signed [127:0] p[3], a[3], b[3], n[3];
    logic signed [127:0] aa, bb, ab, den, ka, kb, num, s;
    center_t r;
    for (int i = 0; i < 3; i++) begin
      p[i] = t.v[i];
      a[i] = t.v[3+i] - p[i];
      b[i] = t.v[6+i] - p[i];
    end
    n[0] = a[1] * b[2] - a[2] * b[1];
    n[1] = a[2] * b[0] - a[0] * b[2];
    n[2] = a[0] * b[1] - a[1] * b[0];
    aa = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    bb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
    ab = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    den = 2 * (aa * bb - ab * ab);
    r.st = ST_OK;
    r.cx = '0;
    r.cy = '0;
    r.cz = '0;
    r.nx = n[0][NORMAL_W-1:0];
    r.ny = n[1][NORMAL_W-1:0];
    r.nz = n[2][NORMAL_W-1:0];
    if (aa == 0 || bb == 0 || (a[0] == b[0] && a[1] == b[1] && a[2] == b[2])) begin
      r.st = ST_COINCIDENT;
    end else if (den == 0) begin
      r.st = ST_COLLINEAR;
    end else begin
      ka = bb * (aa - ab);
      kb = aa * (bb - ab);
      for (int i = 0; i < 3; i++) begin
        num = ka * a[i] + kb * b[i];
        s = num / den + p[i];
        if (s > 128'sd2147483647) begin
          s = 128'sd2147483647;
          r.st = ST_SATURATED;
        end else if (s < -128'sd2147483648) begin
          s = -128'sd2147483648;
          r.st = ST_SATURATED;
        end
        case (i)
          0: r.cx = s[CENTER_W-1:0];
          1: r.cy = s[CENTER_W-1:0];
          default: r.cz = s[CENTER_W-1:0];
        endcase
      end
    end
    return r;
  endfunction

  function automatic triple_t random_triple();
    triple_t t;
    int kind, k;
    int d[3];
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) t.v[i] = CB'($urandom());
    case (kind)
      4, 5: begin
        for (int i = 0; i < 9; i++) t.v[i] = CB'($urandom_range(0, 2000) - 1000);
      end
      6, 7: begin
        k = $urandom_range(0, 4);
        k = (k < 3) ? k - 3 : k - 1;
        for (int i = 0; i < 3; i++) begin
          t.v[i] = CB'($urandom_range(0, 200000) - 100000);
          d[i] = $urandom_range(0, 100000) - 50000;
          t.v[3+i] = CB'(t.v[i] + d[i]);
          t.v[6+i] = CB'(t.v[i] + k * d[i]);
        end
        if (kind == 7) begin
          k = $urandom_range(6, 8);
          t.v[k] = CB'(t.v[k] + ($urandom_range(0, 1) ? 1 : -1));
        end
      end
      8: begin
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          if (k == 0) t.v[3+i] = t.v[i];
          else if (k == 1) t.v[6+i] = t.v[i];
          else t.v[6+i] = t.v[3+i];
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic send_triple(triple_t t, center_t e);
    start_x <= t.v[0];
    start_y <= t.v[1];
    start_z <= t.v[2];
    via_x   <= t.v[3];
    via_y   <= t.v[4];
    via_z   <= t.v[5];
    end_x   <= t.v[6];
    end_y   <= t.v[7];
    end_z   <= t.v[8];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    centers_due.push_back(e);
    n_sent++;
  endtask

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // receiver: stall patterns of its own, plus one long hold-off on request
  initial begin
    int mode, mode_left, cyc;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= $urandom_range(0, 1);
          default: out_stall <= (cyc % 7 < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    center_t e;
    if (!rst && out_valid && !out_stall) begin
      n_got++;
      st_seen[status]++;
      if (centers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d", $time, status);
        errors++;
      end else begin
        e = centers_due.pop_front();
        check_field("status", e.st, status);
        check_field("center_x", e.cx, center_x);
        check_field("center_y", e.cy, center_y);
        check_field("center_z", e.cz, center_z);
        check_field("normal_x", e.nx, normal_x);
        check_field("normal_y", e.ny, normal_y);
        check_field("normal_z", e.nz, normal_z);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_MAX) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_MAX);
      $display("Regression FAIL");
      $finish;
    end
  end

  int dir_pts[N_DIR][9] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{5, 5, 5, 5, 5, 5, 9, 1, 2},
    '{0, 0, 0, 3, 4, 5, 3, 4, 5},
    '{0, 0, 0, 1, 1, 1, 2, 2, 2},
    '{CMIN, CMIN, CMIN, -2, -2, -2, 524284, 524284, 524284},
    '{0, 0, 0, 10, 0, 0, 0, 10, 0},
    '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX},
    '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX},
    '{0, 0, 0, CMAX, 0, 0, CMIN, 1, 0},
    '{0, 0, 0, CMAX, 0, 0, CMIN, -1, 0},
    '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN},
    '{123, -456, 789, -1000, 2000, -3000, 40000, -50000, 60000}
  };
  bit      dir_typed[N_DIR] = '{1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
  status_t dir_st[N_DIR] = '{ST_COINCIDENT, ST_COINCIDENT, ST_COINCIDENT, ST_COLLINEAR,
                             ST_COLLINEAR, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK, ST_OK};

  initial begin
    triple_t t;
    center_t e;
    int burst, gap;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      for (int i = 0; i < 9; i++) t.v[i] = CB'(dir_pts[r][i]);
      if (dir_typed[r]) begin
        e = '{dir_st[r], 0, 0, 0, 0, 0, 0};
      end else begin
        e = predict_center(t);
      end
      send_triple(t, e);
    end

    burst = 0;
    for (int k = 0; k < N_RANDOM; k++) begin
      t = random_triple();
      send_triple(t, predict_center(t));
      if (k == 500) hold_req = 1'b1;
      if (k == 1000) begin
        in_valid <= 1'b0;
        wait (centers_due.size() == 0);
        @(posedge clk);
      end else if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst--;
      end
    end
    in_valid <= 1'b0;

    wait (centers_due.size() == 0);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d point triples, checked %0d results", n_sent, n_got);
    $display("Status seen: ok %0d, coincident %0d, collinear %0d, saturated %0d",
             st_seen[ST_OK], st_seen[ST_COINCIDENT], st_seen[ST_COLLINEAR],
             st_seen[ST_SATURATED]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ccp_pkg.sv
hw/rtl/ccp_delay.sv
hw/rtl/ccp_mul.sv
hw/rtl/ccp_div.sv
hw/rtl/circle_center_from_three_points.sv
hw/rtl/ccp_checker.sv
sim/tb_circle_center_from_three_points.sv
